FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge out of reset
`define XEE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define XEE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/xee_pkg.sv
package xee_pkg;

  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_ATTR = 2'd1;
  localparam logic [1:0] MODE_TEXT = 2'd2;

  localparam int unsigned IDX_W = 3;

  typedef enum logic [2:0] {
    ENT_NONE,
    ENT_QUOT,
    ENT_LT,
    ENT_GT,
    ENT_AMP,
    ENT_LF,
    ENT_CR,
    ENT_TAB
  } ent_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_final;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_end;
  } out_beat_t;

  typedef struct packed {
    logic busy;
    logic adv;
  } xee_status_t;

  // number of output bytes for an entity
  function automatic logic [IDX_W-1:0] ent_len(ent_e ent);
    logic [IDX_W-1:0] n;
    case (ent)
      ENT_NONE: n = 3'd1;
      ENT_QUOT: n = 3'd6;
      ENT_LT:   n = 3'd4;
      ENT_GT:   n = 3'd4;
      default:  n = 3'd5;
    endcase
    return n;
  endfunction

  // byte number idx of the sequence for ent, raw byte for no entity
  function automatic logic [7:0] ent_char(ent_e ent, logic [IDX_W-1:0] idx, logic [7:0] raw);
    logic [7:0] c;
    logic [7:0] tail;
    c = "&";
    tail = ";";
    case (ent)
      ENT_NONE: c = raw;
      ENT_QUOT: begin
        case (idx)
          3'd0:    c = "&";
          3'd1:    c = "q";
          3'd2:    c = "u";
          3'd3:    c = "o";
          3'd4:    c = "t";
          default: c = tail;
        endcase
      end
      ENT_LT, ENT_GT: begin
        case (idx)
          3'd0:    c = "&";
          3'd1:    c = (ent == ENT_LT) ? "l" : "g";
          3'd2:    c = "t";
          default: c = tail;
        endcase
      end
      ENT_AMP: begin
        case (idx)
          3'd0:    c = "&";
          3'd1:    c = "a";
          3'd2:    c = "m";
          3'd3:    c = "p";
          default: c = tail;
        endcase
      end
      default: begin
        // numeric character references
        case (idx)
          3'd0: c = "&";
          3'd1: c = "#";
          3'd2: c = "x";
          3'd3: begin
            case (ent)
              ENT_LF:  c = "A";
              ENT_CR:  c = "D";
              default: c = "9";
            endcase
          end
          default: c = tail;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/xee_classify.sv
module xee_classify (
  input  logic [1:0]    mode_i,
  input  logic [7:0]    byte_i,
  output xee_pkg::ent_e ent_o
);
  import xee_pkg::*;

  always_comb begin
    ent_o = ENT_NONE;
    case (mode_i)
      MODE_ATTR: begin
        case (byte_i)
          8'h22:   ent_o = ENT_QUOT;
          8'h3C:   ent_o = ENT_LT;
          8'h26:   ent_o = ENT_AMP;
          8'h0A:   ent_o = ENT_LF;
          8'h0D:   ent_o = ENT_CR;
          8'h09:   ent_o = ENT_TAB;
          default: ent_o = ENT_NONE;
        endcase
      end
      MODE_TEXT: begin
        case (byte_i)
          8'h3C:   ent_o = ENT_LT;
          8'h3E:   ent_o = ENT_GT;
          8'h26:   ent_o = ENT_AMP;
          default: ent_o = ENT_NONE;
        endcase
      end
      // pass-through and the unused code
      default: ent_o = ENT_NONE;
    endcase
  end

endmodule

FILE: rtl/xee_emit.sv
module xee_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  xee_pkg::ent_e      ent_i,
  input  xee_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output xee_pkg::out_beat_t out_beat_o,
  output xee_pkg::xee_status_t status_o
);
  import xee_pkg::*;

  logic             work_vld_q, work_vld_d;
  ent_e             ent_q, ent_d;
  logic [7:0]       raw_q, raw_d;
  logic             fin_q, fin_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  logic      out_vld_q, out_vld_d;
  out_beat_t out_q, out_d;

  logic adv, work_last, accept;

  assign adv        = !out_vld_q || out_ready_i;
  assign work_last  = (idx_q == ent_len(ent_q) - 3'd1);
  assign in_ready_o = !work_vld_q || (adv && work_last);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    work_vld_d = work_vld_q;
    ent_d      = ent_q;
    raw_d      = raw_q;
    fin_d      = fin_q;
    idx_d      = idx_q;
    if (accept) begin
      work_vld_d = 1'b1;
      ent_d      = ent_i;
      raw_d      = in_beat_i.in_byte;
      fin_d      = in_beat_i.in_final;
      idx_d      = '0;
    end else if (work_vld_q && adv) begin
      if (work_last) begin
        work_vld_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (adv) begin
      out_vld_d         = work_vld_q;
      out_d.out_byte    = ent_char(ent_q, idx_q, raw_q);
      out_d.run_last    = work_last;
      out_d.message_end = work_last && fin_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_vld_q <= 1'b0;
      idx_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      work_vld_q <= work_vld_d;
      idx_q      <= idx_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    raw_q <= raw_d;
    fin_q <= fin_d;
    out_q <= out_d;
  end

  assign out_valid_o     = out_vld_q;
  assign out_beat_o      = out_q;
  assign status_o.busy   = work_vld_q;
  assign status_o.adv    = adv;

endmodule

FILE: rtl/xml_entity_escaper.sv
// an accepted input beat passes through the work register, then the output register
// throughput: one input beat per cycle for bytes copied as they are, while the output
//   takes beats; an escaped byte holds the input until its entity (4 to 6 bytes) is
//   out, the emit stage stepping one entity byte per cycle while the output takes beats
// reset: asynchronous active low, clears both stages and sets pass-through mode
`include "assert_macros.svh"

module xml_entity_escaper (
  input  logic               clk_i,
  input  logic               rst_ni,
  // escape mode register write
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_data_i,
  // raw text beats
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  xee_pkg::in_beat_t  in_beat_i,
  // escaped text beats
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output xee_pkg::out_beat_t out_beat_o
);
  import xee_pkg::*;

  logic [1:0]  mode_q, mode_d;
  ent_e        ent;
  xee_status_t st;
  logic        end_ok, fill_due, take_busy;

  // mode register, always ready to take a write
  assign cfg_ready_o = 1'b1;

  always_comb begin
    mode_d = mode_q;
    if (cfg_valid_i) begin
      mode_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PASS;
    end else begin
      mode_q <= mode_d;
    end
  end

  // pick the entity while the beat is still at the input, so the work
  // register holds everything needed to emit the run
  xee_classify u_classify (
    .mode_i (mode_q),
    .byte_i (in_beat_i.in_byte),
    .ent_o  (ent)
  );

  // work register steps through the entity, output register parts the sides
  xee_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ent_i       (ent),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o),
    .status_o    (st)
  );

  // terms for the checks below
  assign end_ok    = !out_beat_o.message_end || out_beat_o.run_last;
  assign fill_due  = st.busy && !out_valid_o;
  assign take_busy = in_valid_i && in_ready_o && st.busy;

  // end of message only ever rides on the last byte of a run
  `XEE_ASSERT_ALWAYS(a_end_on_last, clk_i, out_valid_o |-> end_ok, "message_end without run_last")
  // a busy work stage always fills an empty output register
  `XEE_ASSERT(a_work_fills_out, clk_i, rst_ni, fill_due |=> out_valid_o, "output not filled")
  // a new beat is taken only when the work stage is free or drains this cycle
  `XEE_ASSERT(a_accept_drains, clk_i, rst_ni, take_busy |-> st.adv, "beat taken over a stalled run")

endmodule

FILE: test/xml_entity_escaper_test.sv
module xml_entity_escaper_test;
  import xee_pkg::*;

  // spare mode code, the block treats it as pass-through
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // characters that some mode rewrites as an entity
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_TICKS = 10;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [1:0] cfg_data_i = MODE_PASS;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_beat_t  in_beat_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_beat_t out_beat_o;

  // one row of the directed table; typed rows carry a single-beat result
  typedef struct {
    logic [1:0] mode;
    logic [7:0] ch;
    logic       fin;
    bit         typed;
    logic [7:0] typed_byte;
  } text_row_t;

  out_beat_t  expected_beats [$];
  logic [1:0] escape_mode_q  = MODE_PASS;
  int         mismatch_count = 0;
  int         cycle_count    = 0;
  int         send_idle_pct  = 0;
  int         out_stall_pct  = 0;

  xml_entity_escaper u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // entity text for a byte under a mode, empty when the byte is copied as is
  function automatic string entity_for(logic [1:0] mode, logic [7:0] ch);
    string ent;
    ent = "";
    if (mode == MODE_ATTR) begin
      case (ch)
        CH_QUOT: ent = "&quot;";
        CH_LT:   ent = "&lt;";
        CH_AMP:  ent = "&amp;";
        CH_LF:   ent = "&#xA;";
        CH_CR:   ent = "&#xD;";
        CH_TAB:  ent = "&#x9;";
        default: ent = "";
      endcase
    end else if (mode == MODE_TEXT) begin
      case (ch)
        CH_LT:   ent = "&lt;";
        CH_GT:   ent = "&gt;";
        CH_AMP:  ent = "&amp;";
        default: ent = "";
      endcase
    end
    return ent;
  endfunction

  // queue the escaped beats for one accepted raw byte
  task automatic expect_escape(in_beat_t raw);
    string     ent;
    out_beat_t ob;
    ent = entity_for(escape_mode_q, raw.in_byte);
    if (ent.len() == 0) begin
      ob.out_byte    = raw.in_byte;
      ob.run_last    = 1'b1;
      ob.message_end = raw.in_final;
      expected_beats.push_back(ob);
    end else begin
      for (int k = 0; k < ent.len(); k++) begin
        ob.out_byte    = ent[k];
        ob.run_last    = (k == ent.len() - 1);
        ob.message_end = (k == ent.len() - 1) && raw.in_final;
        expected_beats.push_back(ob);
      end
    end
  endtask

  // drive one raw beat, with random idle cycles ahead of it; returns at the
  // accepting edge, valid is left high for the caller's next negedge
  task automatic send_beat(in_beat_t raw);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= raw;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop sending and wait for every queued beat to come out
  task automatic drain_output;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
  endtask

  // mode write, only with the block idle
  task automatic write_mode(logic [1:0] mode);
    drain_output();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    escape_mode_q = mode;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random text, biased toward the characters that get rewritten
  function automatic in_beat_t random_text_beat();
    in_beat_t raw;
    if ($urandom_range(1) == 0) begin
      case ($urandom_range(6))
        0:       raw.in_byte = CH_QUOT;
        1:       raw.in_byte = CH_LT;
        2:       raw.in_byte = CH_GT;
        3:       raw.in_byte = CH_AMP;
        4:       raw.in_byte = CH_LF;
        5:       raw.in_byte = CH_CR;
        default: raw.in_byte = CH_TAB;
      endcase
    end else begin
      raw.in_byte = 8'($urandom_range(255));
    end
    raw.in_final = ($urandom_range(7) == 0);
    return raw;
  endfunction

  // receiver: ready changes only at the falling edge
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  // output checker, every accepted beat against the oldest expectation
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected beat: byte %h last %b end %b", out_beat_o.out_byte,
                   out_beat_o.run_last, out_beat_o.message_end);
      end else begin
        want = expected_beats.pop_front();
        if (out_beat_o.out_byte !== want.out_byte || out_beat_o.run_last !== want.run_last ||
            out_beat_o.message_end !== want.message_end) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("beat mismatch: expected byte %h last %b end %b, got byte %h last %b end %b",
                     want.out_byte, want.run_last, want.message_end, out_beat_o.out_byte,
                     out_beat_o.run_last, out_beat_o.message_end);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    text_row_t dir_rows [$];
    text_row_t row;
    out_beat_t ob;
    in_beat_t  raw;

    dir_rows = '{
      // pass-through straight out of reset, field extremes
      '{MODE_PASS,  8'h00,   1'b0, 1'b1, 8'h00},
      '{MODE_PASS,  8'hFF,   1'b1, 1'b1, 8'hFF},
      '{MODE_PASS,  CH_LT,   1'b0, 1'b1, CH_LT},
      '{MODE_PASS,  CH_AMP,  1'b1, 1'b1, CH_AMP},
      // attribute values: every entity, ampersand included
      '{MODE_ATTR,  CH_QUOT, 1'b0, 1'b0, 8'h00},
      '{MODE_ATTR,  CH_LT,   1'b1, 1'b0, 8'h00},
      '{MODE_ATTR,  CH_AMP,  1'b0, 1'b0, 8'h00},
      '{MODE_ATTR,  CH_LF,   1'b0, 1'b0, 8'h00},
      '{MODE_ATTR,  CH_CR,   1'b1, 1'b0, 8'h00},
      '{MODE_ATTR,  CH_TAB,  1'b0, 1'b0, 8'h00},
      '{MODE_ATTR,  CH_GT,   1'b0, 1'b1, CH_GT},
      '{MODE_ATTR,  8'h61,   1'b1, 1'b1, 8'h61},
      // text: three entities, attribute-only characters pass
      '{MODE_TEXT,  CH_LT,   1'b0, 1'b0, 8'h00},
      '{MODE_TEXT,  CH_GT,   1'b1, 1'b0, 8'h00},
      '{MODE_TEXT,  CH_AMP,  1'b0, 1'b0, 8'h00},
      '{MODE_TEXT,  CH_QUOT, 1'b0, 1'b1, CH_QUOT},
      '{MODE_TEXT,  CH_LF,   1'b1, 1'b1, CH_LF},
      '{MODE_TEXT,  8'hFF,   1'b0, 1'b1, 8'hFF},
      // spare mode code behaves as pass-through
      '{MODE_SPARE, CH_LT,   1'b0, 1'b1, CH_LT},
      '{MODE_SPARE, CH_AMP,  1'b1, 1'b1, CH_AMP},
      '{MODE_SPARE, CH_QUOT, 1'b0, 1'b1, CH_QUOT},
      '{MODE_SPARE, 8'h00,   1'b1, 1'b1, 8'h00}
    };

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table, no idling on either side
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.mode != escape_mode_q) write_mode(row.mode);
      raw.in_byte  = row.ch;
      raw.in_final = row.fin;
      send_beat(raw);
      if (row.typed) begin
        ob.out_byte    = row.typed_byte;
        ob.run_last    = 1'b1;
        ob.message_end = row.fin;
        expected_beats.push_back(ob);
      end else begin
        expect_escape(raw);
      end
    end

    // random text, four idle settings, each walking through all mode codes
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin send_idle_pct = 73; out_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  out_stall_pct = 73; end
        default: begin send_idle_pct = 26; out_stall_pct = 26; end
      endcase
      for (int k = 0; k < 4; k++) begin
        write_mode(2'((p + k) % 4));
        for (int n = 0; n < 16; n++) begin
          // now and then hold off until the output is empty
          if ($urandom_range(39) == 0) drain_output();
          raw = random_text_beat();
          send_beat(raw);
          expect_escape(raw);
        end
      end
    end

    drain_output();
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
